[rtl/adad_pkg.sv]
// ----------------------------------------------------------------------------
// adad_pkg: shared types and constants for the Adadelta step update block
// Transaction structs, sequencer states, register codes and reset values.
// ----------------------------------------------------------------------------
package adad_pkg;

	localparam int SLOTS_DEF = 4;

	localparam logic [15:0] DECAY_RST = 16'd655;
	localparam logic [23:0] EPS_RST   = 24'd17;
	localparam logic [47:0] MEAN_MAX  = 48'hFFFF_FFFF_FFFF;

	// register index codes (byte address bit 2)
	localparam logic REG_DECAY = 1'b0;
	localparam logic REG_EPS   = 1'b1;

	typedef struct packed {
		logic [1:0]         slot;
		logic signed [31:0] gradient;
	} item_t;

	typedef struct packed {
		logic signed [31:0] change;
		logic [31:0]        step_size;
		logic               saturated;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GSQ,
		ST_GLD,
		ST_GBL,
		ST_SLD,
		ST_SCHK,
		ST_DIV,
		ST_SQRT,
		ST_CLD,
		ST_CMUL,
		ST_DLD,
		ST_DSQ,
		ST_QLD,
		ST_DBL,
		ST_WB
	} state_t;

endpackage

[rtl/adad_core.sv]
// ----------------------------------------------------------------------------
// adad_core: bit-serial Adadelta update engine
// Holds the per-slot running means and walks one item through a serial
// multiplier, a restoring divider and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module adad_core #(
	parameter int SLOTS = adad_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  adad_pkg::item_t  item,
	input  logic [15:0]      decay,
	input  logic [23:0]      eps,
	output logic             busy,
	output logic             done,
	output adad_pkg::result_t result
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	adad_pkg::state_t state_q, state_d;

	logic [47:0] gm_mem [SLOTS];
	logic [47:0] dm_mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [47:0] gm_rd_q, dm_rd_q;
	logic        rv_q;
	logic [AW-1:0] idx_q;

	logic [65:0] acc_q, mc_q;
	logic [31:0] mp_q;
	logic [31:0] gmag_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        sat_q;
	logic [48:0] num_q, den_q;
	logic [49:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] root_q;
	logic [31:0] step_q;
	logic [31:0] chg_q;
	logic        done_q;
	adad_pkg::result_t res_q;

	logic        accept;
	logic        last;
	logic [6:0]  sm;
	logic [AW-1:0] idx;
	logic [31:0] graw, gmag;
	logic [65:0] madd;
	logic [47:0] old_g, old_d, old_sel;
	logic [47:0] sq_clip;
	logic        sq_ovf;
	logic [48:0] diff;
	logic [49:0] dv_t;
	logic        dv_ge;
	logic [49:0] sr_t, sr_trial;
	logic        sr_ge;
	logic [48:0] cm, cm_lim;
	logic        cm_ovf;
	logic [31:0] cmv;

	assign accept = start && !busy;
	assign last   = (cnt_q == 6'd0);

	// fold slot into range
	always_comb begin
		sm = {5'd0, item.slot};
		for (int i = 0; i < 3; i++) begin
			if (sm >= 7'(SLOTS)) begin
				sm = sm - 7'(SLOTS);
			end
		end
		idx = sm[AW-1:0];
	end

	assign graw = item.gradient;
	assign gmag = graw[31] ? (~graw + 32'd1) : graw;

	assign madd = mp_q[0] ? (acc_q + mc_q) : acc_q;

	assign old_g   = rv_q ? gm_rd_q : 48'd0;
	assign old_d   = rv_q ? dm_rd_q : 48'd0;
	assign old_sel = (state_q == adad_pkg::ST_QLD) ? old_d : old_g;

	// square already carries the +128 rounding term
	assign sq_ovf  = (acc_q[63:56] != 8'd0);
	assign sq_clip = sq_ovf ? adad_pkg::MEAN_MAX : acc_q[55:8];
	assign diff    = {1'b0, sq_clip} - {1'b0, old_sel};

	assign dv_t  = {rem_q[48:0], quo_q[63]};
	assign dv_ge = (dv_t >= {1'b0, den_q});

	assign sr_t     = {rem_q[47:0], quo_q[63:62]};
	assign sr_trial = {16'd0, root_q, 2'b01};
	assign sr_ge    = (sr_t >= sr_trial);

	assign cm     = acc_q[64:16];
	assign cm_lim = neg_q ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
	assign cm_ovf = (cm > cm_lim);
	assign cmv    = cm_ovf ? cm_lim[31:0] : cm[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != adad_pkg::ST_IDLE);
		unique case (state_q)
			adad_pkg::ST_IDLE: if (start) state_d = adad_pkg::ST_GSQ;
			adad_pkg::ST_GSQ:  if (last) state_d = adad_pkg::ST_GLD;
			adad_pkg::ST_GLD:  state_d = adad_pkg::ST_GBL;
			adad_pkg::ST_GBL:  if (last) state_d = adad_pkg::ST_SLD;
			adad_pkg::ST_SLD:  state_d = adad_pkg::ST_SCHK;
			adad_pkg::ST_SCHK: begin
				if (num_q == 49'd0 || {32'd0, num_q[48:32]} >= den_q) begin
					state_d = adad_pkg::ST_CLD;
				end else begin
					state_d = adad_pkg::ST_DIV;
				end
			end
			adad_pkg::ST_DIV:  if (last) state_d = adad_pkg::ST_SQRT;
			adad_pkg::ST_SQRT: if (last) state_d = adad_pkg::ST_CLD;
			adad_pkg::ST_CLD:  state_d = adad_pkg::ST_CMUL;
			adad_pkg::ST_CMUL: if (last) state_d = adad_pkg::ST_DLD;
			adad_pkg::ST_DLD:  state_d = adad_pkg::ST_DSQ;
			adad_pkg::ST_DSQ:  if (last) state_d = adad_pkg::ST_QLD;
			adad_pkg::ST_QLD:  state_d = adad_pkg::ST_DBL;
			adad_pkg::ST_DBL:  if (last) state_d = adad_pkg::ST_WB;
			adad_pkg::ST_WB:   state_d = adad_pkg::ST_IDLE;
			default:           state_d = adad_pkg::ST_IDLE;
		endcase
	end

	// running mean stores, registered read at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			gm_rd_q <= gm_mem[idx];
			dm_rd_q <= dm_mem[idx];
		end
		if (state_q == adad_pkg::ST_SLD) begin
			gm_mem[idx_q] <= acc_q[63:16];
		end
		if (state_q == adad_pkg::ST_WB) begin
			dm_mem[idx_q] <= acc_q[63:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == adad_pkg::ST_WB);
			if (state_q == adad_pkg::ST_WB) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			adad_pkg::ST_IDLE: begin
				if (start) begin
					idx_q  <= idx;
					rv_q   <= vld_q[idx];
					neg_q  <= graw[31];
					sat_q  <= 1'b0;
					gmag_q <= gmag;
					acc_q  <= 66'd128;
					mc_q   <= {34'd0, gmag};
					mp_q   <= gmag;
					cnt_q  <= 6'd31;
				end
			end
			adad_pkg::ST_GSQ, adad_pkg::ST_GBL, adad_pkg::ST_CMUL,
			adad_pkg::ST_DSQ, adad_pkg::ST_DBL: begin
				acc_q <= madd;
				mc_q  <= {mc_q[64:0], 1'b0};
				mp_q  <= {1'b0, mp_q[31:1]};
				cnt_q <= cnt_q - 6'd1;
			end
			adad_pkg::ST_GLD, adad_pkg::ST_QLD: begin
				// mean = old*2^16 + r*(sq - old), rounded
				sat_q <= sat_q | sq_ovf;
				acc_q <= {2'b00, old_sel, 16'h8000};
				mc_q  <= {{17{diff[48]}}, diff};
				mp_q  <= {16'd0, decay};
				cnt_q <= 6'd15;
			end
			adad_pkg::ST_SLD: begin
				num_q <= {1'b0, old_d} + {25'd0, eps};
				den_q <= {1'b0, acc_q[63:16]} + {25'd0, eps};
			end
			adad_pkg::ST_SCHK: begin
				if (num_q == 49'd0) begin
					step_q <= 32'd0;
				end else if ({32'd0, num_q[48:32]} >= den_q) begin
					step_q <= 32'hFFFF_FFFF;
					sat_q  <= 1'b1;
				end else begin
					rem_q <= {33'd0, num_q[48:32]};
					quo_q <= {num_q[31:0], 32'd0};
					cnt_q <= 6'd63;
				end
			end
			adad_pkg::ST_DIV: begin
				quo_q <= {quo_q[62:0], dv_ge};
				if (last) begin
					rem_q  <= 50'd0;
					root_q <= 32'd0;
					cnt_q  <= 6'd31;
				end else begin
					rem_q <= dv_ge ? (dv_t - {1'b0, den_q}) : dv_t;
					cnt_q <= cnt_q - 6'd1;
				end
			end
			adad_pkg::ST_SQRT: begin
				rem_q  <= sr_ge ? (sr_t - sr_trial) : sr_t;
				root_q <= {root_q[30:0], sr_ge};
				quo_q  <= {quo_q[61:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
				if (last) begin
					step_q <= {root_q[30:0], sr_ge};
				end
			end
			adad_pkg::ST_CLD: begin
				acc_q <= 66'd32768;
				mc_q  <= {34'd0, gmag_q};
				mp_q  <= step_q;
				cnt_q <= 6'd31;
			end
			adad_pkg::ST_DLD: begin
				sat_q <= sat_q | cm_ovf;
				chg_q <= neg_q ? (~cmv + 32'd1) : cmv;
				acc_q <= 66'd128;
				mc_q  <= {34'd0, cmv};
				mp_q  <= cmv;
				cnt_q <= 6'd31;
			end
			adad_pkg::ST_WB: begin
				res_q.change    <= chg_q;
				res_q.step_size <= step_q;
				res_q.saturated <= sat_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while engine busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not occupy engine");

	a_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.step_size == 32'd0 |-> result.change == 32'sd0)
		else $error("nonzero change with zero step");

endmodule

[rtl/adadelta_step_update_top.sv]
// ----------------------------------------------------------------------------
// adadelta_step_update_top: Adadelta optimizer step update
// Usage:
//   Items enter on start/item and are taken at an edge with start high and
//   busy low. Each item names a slot and its Q16.16 gradient; the block
//   updates that slot's squared-gradient mean, forms the adaptive step size
//   and the change, then updates the slot's squared-update mean.
//   One result per item appears on result for one cycle with done high; the
//   receiver cannot hold it off.
//   When the step is forced (zero numerator or step overflow), the divider
//   and square root are skipped and done comes sooner. busy drops with
//   done, so one item is in flight at a time and the next one can be taken
//   at the edge that takes the result. The work is done serially by the
//   bit-serial shift-add multiplier (each product and mean blend), the
//   one-bit restoring divider and the square root.
//   Registers on the APB port: decay_rate at 0x0, epsilon at 0x4; write only
//   while busy is low. Reset clears all means to zero and loads the register
//   defaults.
// ----------------------------------------------------------------------------
module adadelta_step_update_top #(
	parameter int SLOTS = adad_pkg::SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	input  adad_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output adad_pkg::result_t result
);

	logic [15:0] decay_q;
	logic [23:0] eps_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= adad_pkg::DECAY_RST;
			eps_q   <= adad_pkg::EPS_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				adad_pkg::REG_DECAY: decay_q <= pwdata[15:0];
				adad_pkg::REG_EPS:   eps_q   <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			adad_pkg::REG_DECAY: prdata = {16'd0, decay_q};
			adad_pkg::REG_EPS:   prdata = {8'd0, eps_q};
			default:             prdata = 32'd0;
		endcase
	end

	adad_core #(
		.SLOTS(SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.decay  (decay_q),
		.eps    (eps_q),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule

[sim/adadelta_step_update_top_test.sv]
// ----------------------------------------------------------------------------
// adadelta_step_update_top_test: self-checking bench for the Adadelta update
// Drives gradients over the command port, programs decay and epsilon over
// APB, predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module adadelta_step_update_top_test;

	localparam logic [47:0] SQ_MAX = 48'hFFFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	adad_pkg::item_t   item;
	logic        busy, done;
	adad_pkg::result_t result;

	adadelta_step_update_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .item(item), .busy(busy), .done(done), .result(result)
	);

	// predictor state
	logic [47:0] eg2_mean [4];
	logic [47:0] ed2_mean [4];
	logic [15:0] decay_q;
	logic [23:0] eps_q;

	adad_pkg::result_t pending_results[$];
	int          fail_count;
	int          result_count;
	int          item_count;
	bit          idle_enable;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [47:0] square_q24(logic [31:0] mag, ref bit sat);
		logic [63:0] sq;
		logic [63:0] v;
		sq = {32'd0, mag} * {32'd0, mag};
		v = (sq + 64'd128) >> 8;
		if (v > {16'd0, SQ_MAX}) begin
			sat = 1'b1;
			v = {16'd0, SQ_MAX};
		end
		return v[47:0];
	endfunction

	function automatic logic [47:0] mean_blend(logic [47:0] old, logic [47:0] sq);
		logic [127:0] acc;
		acc = (128'd65536 - decay_q) * old + 128'(decay_q) * sq + 128'd32768;
		return acc[63:16];
	endfunction

	function automatic logic [31:0] step_root(logic [48:0] num, logic [48:0] den, ref bit sat);
		logic [127:0] target;
		logic [127:0] t;
		logic [31:0]  s;
		if (num == 0)
			return 32'd0;
		if ((num >> 32) >= den) begin
			sat = 1'b1;
			return 32'hFFFF_FFFF;
		end
		target = 128'(num) << 32;
		s = 32'd0;
		for (int b = 31; b >= 0; b--) begin
			t = 128'(s | (32'd1 << b));
			if (t * t * 128'(den) <= target)
				s = s | (32'd1 << b);
		end
		return s;
	endfunction

	function automatic adad_pkg::result_t predict_update(adad_pkg::item_t it);
		int          k;
		bit          neg, sat;
		logic [31:0] gmag, step;
		logic [47:0] gsq, dsq;
		logic [63:0] cmag;
		adad_pkg::result_t r;
		k = it.slot;
		sat = 1'b0;
		neg = it.gradient[31];
		gmag = neg ? -it.gradient : it.gradient;
		gsq = square_q24(gmag, sat);
		eg2_mean[k] = mean_blend(eg2_mean[k], gsq);
		step = step_root(49'(ed2_mean[k]) + eps_q, 49'(eg2_mean[k]) + eps_q, sat);
		cmag = (64'(gmag) * 64'(step) + 64'd32768) >> 16;
		if (neg) begin
			if (cmag > 64'h8000_0000) begin
				cmag = 64'h8000_0000;
				sat = 1'b1;
			end
			r.change = -cmag[31:0];
		end else begin
			if (cmag > 64'h7FFF_FFFF) begin
				cmag = 64'h7FFF_FFFF;
				sat = 1'b1;
			end
			r.change = cmag[31:0];
		end
		dsq = square_q24(cmag[31:0], sat);
		ed2_mean[k] = mean_blend(ed2_mean[k], dsq);
		r.step_size = step;
		r.saturated = sat;
		return r;
	endfunction

	task automatic apb_write(logic regsel, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (regsel == adad_pkg::REG_DECAY)
			decay_q = value[15:0];
		else
			eps_q = value[23:0];
	endtask

	// let all results drain, then a quiet spell covering the longest latency
	task automatic wait_quiet();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (260) @(posedge clk);
	endtask

	task automatic send_item(logic [1:0] slot, logic [31:0] grad);
		adad_pkg::item_t it;
		if (idle_enable)
			while ($urandom_range(99) < 16)
				@(posedge clk);
		it.slot = slot;
		it.gradient = grad;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		pending_results.push_back(predict_update(it));
		item_count++;
		// hold off until busy is visible to avoid double issue
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			adad_pkg::result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				result_count++;
				if (result.change !== exp_r.change) begin
					$error("change exp %h got %h", exp_r.change, result.change);
					fail_count++;
				end
				if (result.step_size !== exp_r.step_size) begin
					$error("step_size exp %h got %h", exp_r.step_size, result.step_size);
					fail_count++;
				end
				if (result.saturated !== exp_r.saturated) begin
					$error("saturated exp %b got %b", exp_r.saturated, result.saturated);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [31:0] grads[8];
		grads = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
		// zero numerator with eps cleared, once with a zero denominator as well
		apb_write(adad_pkg::REG_EPS, 32'd0);
		send_item(2'd0, 32'h0001_0000);
		send_item(2'd1, 32'h0);
		wait_quiet();
		apb_write(adad_pkg::REG_EPS, 32'd17);
		foreach (grads[i])
			send_item(i[1:0], grads[i]);
		send_item(2'd3, 32'h8000_0000);
		send_item(2'd3, 32'h7FFF_FFFF);
		wait_quiet();
	endtask

	task automatic test_config_extremes();
		logic [31:0] decays[3];
		logic [31:0] epss[3];
		decays = '{32'd0, 32'd65535, 32'd32768};
		epss = '{32'hFF_FFFF, 32'd0, 32'd1};
		for (int i = 0; i < 3; i++) begin
			apb_write(adad_pkg::REG_DECAY, decays[i]);
			apb_write(adad_pkg::REG_EPS, epss[i]);
			for (int j = 0; j < 4; j++)
				send_item(j[1:0], $urandom());
			wait_quiet();
		end
	endtask

	task automatic test_random(int count);
		logic [31:0] g;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				wait_quiet();
				apb_write(adad_pkg::REG_DECAY, $urandom_range(65535));
				apb_write(adad_pkg::REG_EPS,
					($urandom_range(3) == 0) ? $urandom() : $urandom_range(4096));
			end
			idle_enable = !(i >= 200 && i < 300);
			case ($urandom_range(3))
				0: g = $urandom();
				1: g = $urandom_range(32'h0003_FFFF);
				2: g = -$urandom_range(32'h0003_FFFF);
				default: g = $urandom() >>> $urandom_range(31);
			endcase
			send_item(2'($urandom_range(3)), g);
		end
		idle_enable = 1'b1;
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		item = '0;
		fail_count = 0;
		result_count = 0;
		item_count = 0;
		idle_enable = 1'b1;
		decay_q = adad_pkg::DECAY_RST;
		eps_q = adad_pkg::EPS_RST;
		for (int i = 0; i < 4; i++) begin
			eg2_mean[i] = '0;
			ed2_mean[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random(580);
		$display("covered %0d transactions, %0d results checked, several decay/epsilon settings",
			item_count, result_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("adadelta_step_update_top_test passed");
		else
			$display("adadelta_step_update_top_test failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("adadelta_step_update_top_test failed");
		$finish;
	end

endmodule

[sim.f]
rtl/adad_pkg.sv
rtl/adad_core.sv
rtl/adadelta_step_update_top.sv
sim/adadelta_step_update_top_test.sv
